// ===== rtl/rau_pkg.sv =====
// Shared types and codes for the rational arithmetic unit.
`default_nettype none
package rau_pkg;
  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;
endpackage
`default_nettype wire

// ===== rtl/rau_mul.sv =====
// Shift-and-add multiplier of two magnitudes, one bit of the multiplier per cycle.
`default_nettype none
module rau_mul #(
  parameter int unsigned W = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [W-1:0]   x,
  input  wire logic [W-1:0]   y,
  output logic                done,
  output logic [2*W-1:0]      prod
);
  import rau_pkg::*;

  localparam int unsigned CW = $clog2(W + 1);

  logic [2*W-1:0] mcand;
  logic [W-1:0]   mplier;
  logic [CW-1:0]  cnt;
  logic           busy;

  // Add the shifted multiplicand for each set multiplier bit
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        mcand  <= {{W{1'b0}}, x};
        mplier <= y;
        prod   <= '0;
        cnt    <= '0;
      end else if (busy) begin
        if (mplier[0]) prod <= prod + mcand;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        cnt    <= cnt + 1'b1;
        if (cnt == CW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("multiplier done without work");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    $past(start) |-> busy) else $error("multiplier did not start");
  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("multiplier still busy at done");
endmodule
`default_nettype wire

// ===== rtl/rational_arithmetic_unit.sv =====
// Top level of the rational arithmetic unit: products, binary gcd, division.
// The products are formed one after another on the shared multiplier, then the
//   binary gcd runs (one subtract or shift per cycle), then two restoring
//   divisions reduce the numerator and the denominator.
// Throughput: one item at a time; a new item is taken once the result is taken.
// Reset: rst, synchronous, clears the sequencer and the output valid.
`default_nettype none
module rational_arithmetic_unit #(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // a_num[31:0], a_den[63:32], b_num[95:64], b_den[127:96]
  input  wire logic [127:0] s_tdata,
  // command[1:0]
  input  wire logic [1:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // result_num[31:0], result_den[63:32]
  output logic [63:0]       m_tdata,
  // status[1:0]
  output logic [1:0]        m_tuser
);
  import rau_pkg::*;

  localparam int unsigned PW = 2 * WIDTH;   // product width
  localparam int unsigned SW = PW + 1;      // sum width
  localparam int unsigned CW = $clog2(SW + 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_MUL1  = 10'b0000000010,
    S_MUL2  = 10'b0000000100,
    S_MUL3  = 10'b0000001000,
    S_COMB  = 10'b0000010000,
    S_GCD   = 10'b0000100000,
    S_DIVN  = 10'b0001000000,
    S_DIVD  = 10'b0010000000,
    S_FIT   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state;

  logic [WIDTH-1:0] an_m, ad_m, bn_m, bd_m;
  logic             an_s, ad_s, bn_s, bd_s;
  cmd_t             cmd;

  // decode a field as WIDTH-bit two's complement
  function automatic logic [WIDTH:0] dec(input logic [31:0] raw);
    logic [WIDTH-1:0] v;
    logic             n;
    v = raw[WIDTH-1:0];
    n = v[WIDTH-1];
    return {n, n ? (~v + 1'b1) : v};
  endfunction

  logic [WIDTH:0] d_an, d_ad, d_bn, d_bd;
  assign d_an = dec(s_tdata[31:0]);
  assign d_ad = dec(s_tdata[63:32]);
  assign d_bn = dec(s_tdata[95:64]);
  assign d_bd = dec(s_tdata[127:96]);

  // shared multiplier
  logic             m_start, m_done;
  logic [WIDTH-1:0] m_x, m_y;
  logic [PW-1:0]    m_p;

  rau_mul #(.W(WIDTH)) u_mul (
    .clk(clk), .rst(rst), .start(m_start), .x(m_x), .y(m_y),
    .done(m_done), .prod(m_p)
  );

  logic [PW-1:0] p1, p2;          // first and second product
  logic          p1_s, p2_s;
  logic [SW-1:0] num_m, den_m;
  logic          num_s, den_s;
  logic [SW-1:0] gu, gv;          // binary gcd operands
  logic [CW-1:0] gk;              // exponent of the common factor of two
  logic [SW-1:0] gcd;
  logic [SW-1:0] quo, rem, dvd;
  logic [CW-1:0] dcnt;
  logic [1:0]    st;
  logic [31:0]   r_num, r_den;
  logic          started;

  // operand selection for each product
  always_comb begin
    m_x = an_m;
    m_y = bd_m;
    unique case (state)
      S_MUL2: begin
        if (cmd == CMD_DIV) begin m_x = ad_m; m_y = bn_m; end
        else if (cmd == CMD_MUL) begin m_x = an_m; m_y = bn_m; end
        else begin m_x = bn_m; m_y = ad_m; end
      end
      S_MUL3: begin m_x = ad_m; m_y = bd_m; end
      default: ;
    endcase
  end
  assign m_start = !started && (state == S_MUL1 || state == S_MUL2 || state == S_MUL3);

  logic [SW-1:0] sub_uv;
  assign sub_uv = gu - gv;
  logic [SW:0] trial;
  assign trial = {rem, dvd[SW-1]} - {1'b0, gcd};

  logic lim_ok_n, lim_ok_d;
  logic [SW-1:0] lim;
  assign lim = SW'(1) << (WIDTH - 1);
  assign lim_ok_n = num_s ? (num_m <= lim) : (num_m < lim);
  assign lim_ok_d = den_s ? (den_m <= lim) : (den_m < lim);

  logic [WIDTH-1:0] enc_n, enc_d;
  assign enc_n = num_s ? (~num_m[WIDTH-1:0] + 1'b1) : num_m[WIDTH-1:0];
  assign enc_d = den_s ? (~den_m[WIDTH-1:0] + 1'b1) : den_m[WIDTH-1:0];

  logic [SW-1:0] pa, pb;
  logic          pa_s, pb_s;
  always_comb begin
    pa   = {1'b0, p1};
    pb   = {1'b0, p2};
    pa_s = p1_s && (p1 != '0);
    pb_s = (cmd == CMD_SUB) ? !p2_s : p2_s;
    pb_s = pb_s && (p2 != '0);
  end

  assign s_tready = (state == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      started  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (s_tvalid) begin
          cmd   <= cmd_t'(s_tuser);
          an_s  <= d_an[WIDTH]; an_m <= d_an[WIDTH-1:0];
          ad_s  <= d_ad[WIDTH]; ad_m <= d_ad[WIDTH-1:0];
          bn_s  <= d_bn[WIDTH]; bn_m <= d_bn[WIDTH-1:0];
          bd_s  <= d_bd[WIDTH]; bd_m <= d_bd[WIDTH-1:0];
          state <= S_MUL1;
        end
        S_MUL1: begin
          started <= 1'b1;
          if (m_done) begin
            p1 <= m_p; p1_s <= an_s ^ bd_s; started <= 1'b0; state <= S_MUL2;
          end
        end
        S_MUL2: begin
          started <= 1'b1;
          if (m_done) begin
            p2 <= m_p; started <= 1'b0; state <= S_MUL3;
            if (cmd == CMD_DIV) p2_s <= ad_s ^ bn_s;
            else if (cmd == CMD_MUL) p2_s <= an_s ^ bn_s;
            else p2_s <= bn_s ^ ad_s;
          end
        end
        S_MUL3: begin
          started <= 1'b1;
          if (m_done) begin
            started <= 1'b0;
            den_m   <= {1'b0, m_p};
            den_s   <= (ad_s ^ bd_s) && (m_p != '0);
            state   <= S_COMB;
          end
        end
        S_COMB: begin
          // form the numerator (and for a division the denominator), then start the gcd
          if (cmd == CMD_MUL || cmd == CMD_DIV) begin
            if (cmd == CMD_DIV) begin
              num_m <= pa; num_s <= pa_s;
              den_m <= pb; den_s <= p2_s && (p2 != '0);
              gu <= pa; gv <= pb;
            end else begin
              num_m <= pb; num_s <= pb_s;
              gu <= pb; gv <= den_m;
            end
          end else begin
            if (pa_s == pb_s) begin
              num_m <= pa + pb; num_s <= pa_s; gu <= pa + pb;
            end else if (pa >= pb) begin
              num_m <= pa - pb; num_s <= pa_s && (pa != pb); gu <= pa - pb;
            end else begin
              num_m <= pb - pa; num_s <= pb_s; gu <= pb - pa;
            end
            gv <= den_m;
          end
          gk    <= '0;
          state <= S_GCD;
        end
        S_GCD: begin
          // binary gcd, one shift or subtract per cycle
          if (gv == '0) begin
            st <= ST_ZERO_DEN;
            state <= S_FIT;
          end else if (gu == '0) begin
            gcd <= gv << gk; state <= S_DIVN;
            dvd <= num_m; rem <= '0; dcnt <= '0;
          end else if (!gu[0] && !gv[0]) begin
            gu <= gu >> 1; gv <= gv >> 1; gk <= gk + 1'b1;
          end else if (!gu[0]) gu <= gu >> 1;
          else if (!gv[0]) gv <= gv >> 1;
          else if (gu >= gv) gu <= sub_uv >> 1;
          else gv <= (gv - gu) >> 1;
        end
        S_DIVN, S_DIVD: begin
          // restoring division, one quotient bit per cycle
          if (!trial[SW]) rem <= trial[SW-1:0];
          else rem <= {rem[SW-2:0], dvd[SW-1]};
          quo  <= {quo[SW-2:0], !trial[SW]};
          dvd  <= dvd << 1;
          dcnt <= dcnt + 1'b1;
          if (dcnt == CW'(SW - 1)) begin
            dcnt <= '0;
            rem  <= '0;
            if (state == S_DIVN) begin
              num_m <= {quo[SW-2:0], !trial[SW]};
              dvd   <= den_m;
              state <= S_DIVD;
            end else begin
              den_m <= {quo[SW-2:0], !trial[SW]};
              st    <= ST_OK;
              state <= S_FIT;
            end
          end
        end
        S_FIT: begin
          if (st == ST_OK && (num_m == '0)) num_s <= 1'b0;
          state <= S_OUT;
          m_tvalid <= 1'b1;
          if (st == ST_ZERO_DEN) begin
            r_num <= '0; r_den <= '0;
          end else if (!(lim_ok_n || num_m == '0) || !lim_ok_d) begin
            st <= ST_OVERFLOW; r_num <= '0; r_den <= '0;
          end else begin
            r_num <= 32'(signed'(num_m == '0 ? '0 : enc_n));
            r_den <= 32'(signed'(enc_d));
          end
        end
        S_OUT: if (m_tready) begin
          m_tvalid <= 1'b0;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {r_den, r_num};
  assign m_tuser = st;

  a_valid_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> state == S_OUT) else $error("result valid outside output state");
  a_busy_ready: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_tready) else $error("ready while busy");
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_ZERO_DEN || m_tuser == ST_OVERFLOW))
    else $error("bad status code");
endmodule
`default_nettype wire

// ===== dv/rational_arithmetic_unit_tb.sv =====
// Testbench for the rational arithmetic unit: directed and random fractions checked by a scoreboard.
`timescale 1ns / 100ps
`default_nettype none
module rational_arithmetic_unit_tb;
  import rau_pkg::*;

  typedef struct {
    logic [31:0] num;
    logic [31:0] den;
    status_t     status;
  } fraction_res_t;

  // Signed magnitude helpers for exact 64-bit intermediate math
  typedef struct {
    bit          neg;
    logic [63:0] mag;
  } smag_t;

  function automatic smag_t to_smag(logic [31:0] raw);
    smag_t r;
    r.neg = raw[31];
    r.mag = raw[31] ? {32'd0, -raw} : {32'd0, raw};
    return r;
  endfunction

  function automatic smag_t smag_mul(smag_t x, smag_t y);
    smag_t r;
    r.mag = x.mag * y.mag;
    r.neg = (x.neg != y.neg) && (r.mag != 0);
    return r;
  endfunction

  function automatic smag_t smag_add(smag_t x, smag_t y);
    smag_t r;
    if (x.neg == y.neg) begin
      r.mag = x.mag + y.mag;
      r.neg = x.neg;
    end else if (x.mag >= y.mag) begin
      r.mag = x.mag - y.mag;
      r.neg = x.neg;
    end else begin
      r.mag = y.mag - x.mag;
      r.neg = y.neg;
    end
    if (r.mag == 0) r.neg = 0;
    return r;
  endfunction

  function automatic bit smag_fits(smag_t x);
    return x.neg ? (x.mag <= 64'h8000_0000) : (x.mag < 64'h8000_0000);
  endfunction

  // Compute the reduced fraction for one command
  function automatic fraction_res_t reduce_fraction(cmd_t cmd, logic [31:0] an_r,
      logic [31:0] ad_r, logic [31:0] bn_r, logic [31:0] bd_r);
    smag_t an, ad, bn, bd, num, den, t;
    logic [63:0] p, q, tmp;
    fraction_res_t r;
    an = to_smag(an_r);
    ad = to_smag(ad_r);
    bn = to_smag(bn_r);
    bd = to_smag(bd_r);
    case (cmd)
      CMD_ADD: begin
        num = smag_add(smag_mul(an, bd), smag_mul(bn, ad));
        den = smag_mul(ad, bd);
      end
      CMD_SUB: begin
        t = smag_mul(bn, ad);
        if (t.mag != 0) t.neg = !t.neg;
        num = smag_add(smag_mul(an, bd), t);
        den = smag_mul(ad, bd);
      end
      CMD_MUL: begin
        num = smag_mul(an, bn);
        den = smag_mul(ad, bd);
      end
      default: begin
        num = smag_mul(an, bd);
        den = smag_mul(ad, bn);
      end
    endcase
    r.num = '0;
    r.den = '0;
    if (den.mag == 0) begin
      r.status = ST_ZERO_DEN;
      return r;
    end
    p = num.mag;
    q = den.mag;
    while (q != 0) begin
      tmp = p % q;
      p = q;
      q = tmp;
    end
    num.mag = num.mag / p;
    den.mag = den.mag / p;
    if (num.mag == 0) num.neg = 0;
    if (!smag_fits(num) || !smag_fits(den)) begin
      r.status = ST_OVERFLOW;
      return r;
    end
    r.num = num.neg ? -num.mag[31:0] : num.mag[31:0];
    r.den = den.neg ? -den.mag[31:0] : den.mag[31:0];
    r.status = ST_OK;
    return r;
  endfunction

  int mismatch_count = 0;

  task automatic report_mismatch(string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  class fraction_scoreboard;
    fraction_res_t pending[$];

    function void note_item(logic [1:0] cmd, logic [127:0] data);
      pending.insert(pending.size(), reduce_fraction(cmd_t'(cmd), data[31:0],
                     data[63:32], data[95:64], data[127:96]));
    endfunction

    task check_result(logic [63:0] data, logic [1:0] status);
      fraction_res_t e;
      if (pending.size() == 0) begin
        report_mismatch("result with no item outstanding");
        return;
      end
      e = pending.pop_front();
      if (status !== e.status)
        report_mismatch($sformatf("status %0d, want %0d", status, e.status));
      if (data[31:0] !== e.num)
        report_mismatch($sformatf("num %h, want %h", data[31:0], e.num));
      if (data[63:32] !== e.den)
        report_mismatch($sformatf("den %h, want %h", data[63:32], e.den));
    endtask
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [63:0]  m_tdata;
  logic [1:0]   m_tuser;

  rational_arithmetic_unit u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  fraction_scoreboard sb = new();
  int  send_idle_pct = 35;
  int  recv_idle_pct = 50;
  bit  recv_hold = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("rational_arithmetic_unit test failed");
    $finish;
  end

  // Sample accepted items and results at the rising edge
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_item(s_tuser, s_tdata);
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
  end

  // Receiver ready, random or held off
  always @(negedge clk) begin
    if (recv_hold) m_tready <= 0;
    else m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Offer one item; valid drops only while the sender idles
  task automatic send_item(cmd_t cmd, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [31:0] bd);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= cmd;
    s_tdata  <= {bd, bn, ad, an};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Mix of small, edge and full-range operand values
  function automatic logic [31:0] rand_operand();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(0, 40) - 20;
      2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      3: return 32'(1) << $urandom_range(31);
      4: return $urandom & 32'h0000_ffff;
      default: return $urandom_range(0, 2000) - 1000;
    endcase
  endfunction

  task automatic send_random(int count);
    repeat (count)
      send_item(cmd_t'($urandom_range(3)), rand_operand(), rand_operand(),
                rand_operand(), rand_operand());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: each command, zero numerator and denominator, extremes
    send_item(CMD_ADD, 1, 2, 1, 3);
    send_item(CMD_SUB, 1, 2, 1, 3);
    send_item(CMD_MUL, 2, 3, 3, 4);
    send_item(CMD_DIV, 2, 3, 3, 4);
    send_item(CMD_ADD, 0, -5, 0, 7);
    send_item(CMD_MUL, 0, -5, 3, 7);
    send_item(CMD_ADD, 1, 0, 1, 3);
    send_item(CMD_DIV, 1, 2, 0, 3);
    send_item(CMD_SUB, 3, 4, 3, 4);
    send_item(CMD_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1);
    send_item(CMD_MUL, 32'h8000_0000, 1, 1, 1);
    send_item(CMD_DIV, 32'h8000_0000, 1, -1, 1);
    send_item(CMD_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_item(CMD_SUB, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_item(CMD_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_item(CMD_DIV, -6, 4, 9, -2);
    send_item(CMD_MUL, 32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555);

    // Hold the receiver off while items keep coming
    fork
      begin
        recv_hold = 1;
        repeat (1500) @(posedge clk);
        recv_hold = 0;
      end
      send_random(6);
    join

    send_random(230);
    send_idle_pct = 50;
    recv_idle_pct = 35;
    send_random(230);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(230);
    s_tvalid <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (mismatch_count == 0) $display("rational_arithmetic_unit test passed");
    else $display("rational_arithmetic_unit test failed");
    $finish;
  end
endmodule
`default_nettype wire
